>>> design/mandelbrot_escape_colour_core_defines.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape core assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_COLOUR_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_COLOUR_CORE_DEFINES_SVH

// same-cycle implication
`define MEC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mec assertion failed: same-cycle implication");

// next-cycle implication
`define MEC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mec assertion failed: next-cycle implication");

`endif

>>> design/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg
// Types, constants and helpers for the Mandelbrot escape-time core.
// ----------------------------------------------------------------------------
`default_nettype none

package mec_pkg;

  localparam int COORD_BITS_DEF = 12;

  // iteration cap, applied on top of the programmed limit
  localparam int             MAX_ITERATIONS = 1023;
  localparam logic [9:0]     LIMIT_CAP      = 10'(MAX_ITERATIONS);

  // Q4.28 fraction bits
  localparam int Q_FRAC = 28;

  // register indexes on the config port
  localparam logic [1:0] CFG_STEP_SIZE  = 2'd0;
  localparam logic [1:0] CFG_RADIUS_SQ  = 2'd1;
  localparam logic [1:0] CFG_ITER_LIMIT = 2'd2;

  localparam logic [28:0] STEP_SIZE_RST  = 29'd1342177;
  localparam logic [30:0] RADIUS_SQ_RST  = 31'd1073741824;
  localparam logic [9:0]  ITER_LIMIT_RST = 10'd256;

  // colour constants
  localparam logic [7:0] ALPHA       = 8'hcc;
  localparam logic [7:0] RED_MUL     = 8'd11;
  localparam logic [7:0] GREEN_EVEN  = 8'd10;
  localparam logic [7:0] GREEN_ODD   = 8'd35;
  localparam logic [7:0] BLUE_BASE   = 8'd180;
  localparam logic [7:0] BLUE_ODD    = 8'd120;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CX,
    ST_CY,
    ST_INIT,
    ST_SQX,
    ST_SQY,
    ST_TEST,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_CX,
    MS_CY,
    MS_XX,
    MS_YY,
    MS_XY
  } mul_sel_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_op_t;

  // clamp to signed 32-bit Q4.28
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (!v[63] && (|v[62:31])) begin
      r = 32'sh7fffffff;
    end else if (v[63] && !(&v[62:31])) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/mandelbrot_escape_colour_core.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_colour_core: one result word per start, when the limit L is reached (not escaped)
// or when escape is seen at count k; busy drops in the strobe cycle.
// One shared 32x32 multiplier, used three times per iteration, sets the loop of states SQX, SQY, TEST and UPD.
// Synchronous active-low reset idles the sequencer and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mandelbrot_escape_colour_core_defines.svh"

module mandelbrot_escape_colour_core #(
  parameter int COORD_BITS = mec_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command side
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_BITS-1:0] in_pixel_x,
  input  wire logic [COORD_BITS-1:0] in_pixel_y,
  // result side
  output logic                       out_strobe,
  output logic                       out_escaped,
  output logic [9:0]                 out_escape_count,
  output logic [31:0]                out_colour_word,
  // config write
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [31:0]           cfg_data
);

  localparam int EXT_BITS = 32 - COORD_BITS;

  mec_pkg::state_t state_r, state_nxt;

  logic [28:0] step_r;
  logic [30:0] radius_r;
  logic [9:0]  ilim_r;

  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic signed [31:0] cx_r, cy_r, zx_r, zy_r;
  logic [34:0] sqx_r, sqy_r;
  logic [9:0]  count_r, lim_r;
  logic        esc_r;

  logic        strobe_r, escaped_r;
  logic [9:0]  cnt_out_r;
  logic [31:0] colour_r;

  mec_pkg::mul_sel_t  mul_sel;
  mec_pkg::mul_op_t   mul_op;
  logic signed [63:0] prod;

  logic               accept;
  logic [9:0]         lim_eff;
  logic signed [31:0] prod_sat;
  logic [34:0]        sq_now;
  logic               esc_hit;
  logic signed [31:0] nx, ny;
  logic               last_iter;
  logic               parity;
  logic [7:0]         red, green, blue;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign lim_eff   = (ilim_r > mec_pkg::LIMIT_CAP) ? mec_pkg::LIMIT_CAP : ilim_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= mec_pkg::STEP_SIZE_RST;
      radius_r <= mec_pkg::RADIUS_SQ_RST;
      ilim_r   <= mec_pkg::ITER_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mec_pkg::CFG_STEP_SIZE:  step_r   <= cfg_data[28:0];
        mec_pkg::CFG_RADIUS_SQ:  radius_r <= cfg_data[30:0];
        mec_pkg::CFG_ITER_LIMIT: ilim_r   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  mec_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  // datapath terms off the product register
  assign prod_sat  = mec_pkg::sat32(prod);
  assign sq_now    = prod[62:28];
  assign esc_hit   = ({1'b0, sqx_r} + {1'b0, sq_now}) > {5'd0, radius_r};
  assign nx        = mec_pkg::sat32($signed({29'd0, sqx_r}) - $signed({29'd0, sqy_r})
                                    + 64'(cx_r));
  assign ny        = mec_pkg::sat32((prod >>> (mec_pkg::Q_FRAC - 1)) + 64'(cy_r));
  assign last_iter = ({1'b0, count_r} + 11'd1) >= {1'b0, lim_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mec_pkg::ST_IDLE: if (start) state_nxt = mec_pkg::ST_CX;
      mec_pkg::ST_CX:   state_nxt = mec_pkg::ST_CY;
      mec_pkg::ST_CY:   state_nxt = mec_pkg::ST_INIT;
      mec_pkg::ST_INIT: state_nxt = (lim_r == 10'd0) ? mec_pkg::ST_DONE : mec_pkg::ST_SQX;
      mec_pkg::ST_SQX:  state_nxt = mec_pkg::ST_SQY;
      mec_pkg::ST_SQY:  state_nxt = mec_pkg::ST_TEST;
      mec_pkg::ST_TEST: state_nxt = esc_hit ? mec_pkg::ST_DONE : mec_pkg::ST_UPD;
      mec_pkg::ST_UPD:  state_nxt = last_iter ? mec_pkg::ST_DONE : mec_pkg::ST_SQX;
      mec_pkg::ST_DONE: state_nxt = mec_pkg::ST_IDLE;
      default:          state_nxt = mec_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy    = (state_r != mec_pkg::ST_IDLE);
    mul_sel = mec_pkg::MS_NONE;
    case (state_r)
      mec_pkg::ST_CX:   mul_sel = mec_pkg::MS_CX;
      mec_pkg::ST_CY:   mul_sel = mec_pkg::MS_CY;
      mec_pkg::ST_SQX:  mul_sel = mec_pkg::MS_XX;
      mec_pkg::ST_SQY:  mul_sel = mec_pkg::MS_YY;
      mec_pkg::ST_TEST: mul_sel = mec_pkg::MS_XY;
      default:          mul_sel = mec_pkg::MS_NONE;
    endcase
  end

  // multiplier operand mux
  always_comb begin
    mul_op = '0;
    case (mul_sel)
      mec_pkg::MS_CX: begin
        mul_op.a = {{EXT_BITS{px_r[COORD_BITS-1]}}, px_r};
        mul_op.b = {3'd0, step_r};
      end
      mec_pkg::MS_CY: begin
        mul_op.a = {{EXT_BITS{py_r[COORD_BITS-1]}}, py_r};
        mul_op.b = {3'd0, step_r};
      end
      mec_pkg::MS_XX: begin
        mul_op.a = zx_r;
        mul_op.b = zx_r;
      end
      mec_pkg::MS_YY: begin
        mul_op.a = zy_r;
        mul_op.b = zy_r;
      end
      mec_pkg::MS_XY: begin
        mul_op.a = zx_r;
        mul_op.b = zy_r;
      end
      default: mul_op = '0;
    endcase
  end

  // colour from the final count
  assign parity = count_r[0];
  assign red    = 8'(count_r[7:0] * mec_pkg::RED_MUL);
  assign green  = parity ? mec_pkg::GREEN_ODD : mec_pkg::GREEN_EVEN;
  assign blue   = 8'(mec_pkg::BLUE_BASE - count_r[7:0] - (parity ? mec_pkg::BLUE_ODD : 8'd0));

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mec_pkg::ST_IDLE;
      count_r  <= '0;
      lim_r    <= '0;
      esc_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == mec_pkg::ST_DONE);
      if (accept) begin
        count_r <= '0;
        lim_r   <= lim_eff;
        esc_r   <= 1'b0;
      end
      if (state_r == mec_pkg::ST_TEST && esc_hit) esc_r <= 1'b1;
      if (state_r == mec_pkg::ST_UPD) count_r <= count_r + 10'd1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
    end
    case (state_r)
      mec_pkg::ST_CY: begin
        cx_r <= prod_sat;
        zx_r <= prod_sat;
      end
      mec_pkg::ST_INIT: begin
        cy_r <= prod_sat;
        zy_r <= prod_sat;
      end
      mec_pkg::ST_SQY:  sqx_r <= sq_now;
      mec_pkg::ST_TEST: sqy_r <= sq_now;
      mec_pkg::ST_UPD: begin
        zx_r <= nx;
        zy_r <= ny;
      end
      mec_pkg::ST_DONE: begin
        escaped_r <= esc_r;
        cnt_out_r <= count_r;
        colour_r  <= {mec_pkg::ALPHA, red, green, blue};
      end
      default: ;
    endcase
  end

  assign out_strobe       = strobe_r;
  assign out_escaped      = escaped_r;
  assign out_escape_count = cnt_out_r;
  assign out_colour_word  = colour_r;

  `MEC_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `MEC_ASSERT_IMP(a_strobe_idle, out_strobe, !busy)
  `MEC_ASSERT_IMP(a_count_bound, busy, count_r <= lim_r)
  `MEC_ASSERT_IMP(a_escape_below_limit, out_strobe && out_escaped, out_escape_count < lim_r)

endmodule

`default_nettype wire

>>> design/mec_mul.sv
// ----------------------------------------------------------------------------
// mec_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module mec_mul (
  input  wire logic                clk,
  input  wire mec_pkg::mul_op_t    op,
  output logic signed [63:0]       prod
);

  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= $signed(op.a) * $signed(op.b);
  end

  assign prod = prod_r;

endmodule

`default_nettype wire
